[design/sfec_pkg.sv]
package sfec_pkg;

    // Internal widths sized for the largest grid (15 x 15 sites, 16 rounds)
    localparam int STEP_W      = 4;
    localparam int COORD_W     = 4;
    localparam int SITE_W      = 8;
    localparam int SLOT_W      = 5;
    localparam int IDX_W       = 14;
    localparam int PORT_SLOT_W = 4;
    localparam int PORT_SITE_W = 7;
    localparam int VALUE_W     = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef enum logic {
        CMD_BIT  = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

    typedef enum logic {
        RESULT_OUTCOME = 1'b0,
        RESULT_READ    = 1'b1
    } t_kind;

    typedef struct packed {
        logic [STEP_W-1:0]  step;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [SITE_W-1:0]  site;
    } t_flip;

    // One histogram operation: a read, or an end-of-shot outcome
    typedef struct packed {
        t_kind                  kind;
        logic                   access;
        logic                   matched;
        logic [1:0]             flips;
        logic                   edge_type;
        logic [PORT_SLOT_W-1:0] edge_slot;
        logic [PORT_SITE_W-1:0] edge_site;
        logic [IDX_W-1:0]       idx;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic clearing;
    } t_back_status;

endpackage

[design/sfec_front.sv]
module sfec_front #(
    parameter int WIDTH        = 9,
    parameter int ROUNDS       = 8,
    parameter int BOUNDARY_SUM = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_command,
    input  logic                              i_syndrome_bit,
    input  logic                              i_read_type,
    input  logic [sfec_pkg::PORT_SLOT_W-1:0]  i_read_slot,
    input  logic [sfec_pkg::PORT_SITE_W-1:0]  i_read_site,
    input  sfec_pkg::t_back_status            i_back,
    input  sfec_pkg::t_q_status               i_q,
    output logic                              o_push,
    output sfec_pkg::t_job                    o_job
);
    import sfec_pkg::*;

    localparam int SITES   = WIDTH * WIDTH;
    localparam int SLOTS   = 2 * ROUNDS - 1;
    localparam int LSITE_W = $clog2(SITES);
    localparam int ROW_W   = $clog2(WIDTH);
    localparam int ROUND_W = $clog2(ROUNDS + 1);

    localparam logic [SITE_W:0] D_P2  = (SITE_W+1)'(2);
    localparam logic [SITE_W:0] D_M2  = (SITE_W+1)'(-2);
    localparam logic [SITE_W:0] D_PW  = (SITE_W+1)'(2 * WIDTH);
    localparam logic [SITE_W:0] D_MW  = (SITE_W+1)'(-2 * WIDTH);
    localparam logic [STEP_W:0] DS_P1 = (STEP_W+1)'(1);
    localparam logic [STEP_W:0] DS_M1 = (STEP_W+1)'(-1);
    localparam logic [COORD_W:0] BSUM = (COORD_W+1)'(BOUNDARY_SUM);

    logic adv;
    logic accept;
    logic accept_bit;

    // shot position
    logic [LSITE_W-1:0] r_site_pos;
    logic [ROW_W-1:0]   r_row_pos;
    logic [ROW_W-1:0]   r_col_pos;
    logic [ROUND_W-1:0] r_round_pos;

    // previous-round bit store
    logic r_prev [SITES];
    logic r_prev_q;

    // stage 1: accepted beat
    logic                   r_s1_valid;
    t_cmd                   r_s1_cmd;
    logic                   r_s1_bit;
    logic [ROUND_W-1:0]     r_s1_round;
    logic [ROW_W-1:0]       r_s1_row;
    logic [ROW_W-1:0]       r_s1_col;
    logic [LSITE_W-1:0]     r_s1_site;
    logic                   r_s1_last;
    logic                   r_s1_rd_type;
    logic [PORT_SLOT_W-1:0] r_s1_rd_slot;
    logic [PORT_SITE_W-1:0] r_s1_rd_site;

    // flip tracking
    t_flip      r_rec0, r_rec1, n_rec0, n_rec1, new_rec;
    logic [1:0] r_cnt, n_cnt;
    logic       s1_bit_go;
    logic       flip;

    // stage 2: shot end or read
    logic                   r_s2_valid;
    t_kind                  r_s2_kind;
    logic [1:0]             r_s2_cnt;
    t_flip                  r_s2_rec0, r_s2_rec1;
    logic                   r_s2_rd_type;
    logic [PORT_SLOT_W-1:0] r_s2_rd_slot;
    logic [PORT_SITE_W-1:0] r_s2_rd_site;

    // edge match
    logic [COORD_W:0]  pos_sum;
    logic              one_hit;
    logic [SITE_W-1:0] one_site;
    logic [SITE_W:0]   d;
    logic [STEP_W:0]   ds;
    logic [SITE_W:0]   pair_sum;
    logic [SLOT_W-1:0] step_sum;
    logic [SLOT_W-1:0] step_dbl;
    logic              near;
    logic              adj;
    logic              two_hit;
    logic [SLOT_W-1:0] two_slot;
    logic [SITE_W-1:0] two_site;
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic [SITE_W-1:0] hit_site;
    logic              rd_ok;

    // stage 3: classified operation
    logic              r_s3_valid;
    t_kind             r_s3_kind;
    logic              r_s3_access;
    logic              r_s3_matched;
    logic [1:0]        r_s3_flips;
    logic              r_s3_type;
    logic [SLOT_W-1:0] r_s3_slot;
    logic [SITE_W-1:0] r_s3_site;
    logic [SLOT_W:0]   type_slot;

    assign adv        = !i_q.full;
    assign o_in_ready = adv && !i_back.clearing;
    assign accept     = i_in_valid && o_in_ready;
    assign accept_bit = accept && (t_cmd'(i_command) == CMD_BIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_site_pos  <= '0;
            r_row_pos   <= '0;
            r_col_pos   <= '0;
            r_round_pos <= '0;
        end else if (accept_bit) begin
            if (r_col_pos == ROW_W'(WIDTH - 1)) begin
                r_col_pos <= '0;
                r_row_pos <= (r_row_pos == ROW_W'(WIDTH - 1)) ? '0 : r_row_pos + 1'b1;
            end else begin
                r_col_pos <= r_col_pos + 1'b1;
            end
            if (r_site_pos == LSITE_W'(SITES - 1)) begin
                r_site_pos  <= '0;
                r_round_pos <= (r_round_pos == ROUND_W'(ROUNDS)) ? '0 : r_round_pos + 1'b1;
            end else begin
                r_site_pos <= r_site_pos + 1'b1;
            end
        end
    end

    // Same site comes back only one round later, so read and write never collide
    always_ff @(posedge i_clk) begin
        if (accept_bit) begin
            r_prev_q <= r_prev[r_site_pos];
        end
        if (s1_bit_go) begin
            r_prev[r_s1_site] <= r_s1_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_cmd     <= t_cmd'(i_command);
            r_s1_bit     <= i_syndrome_bit;
            r_s1_round   <= r_round_pos;
            r_s1_row     <= r_row_pos;
            r_s1_col     <= r_col_pos;
            r_s1_site    <= r_site_pos;
            r_s1_last    <= (t_cmd'(i_command) == CMD_BIT)
                            && (r_site_pos == LSITE_W'(SITES - 1))
                            && (r_round_pos == ROUND_W'(ROUNDS));
            r_s1_rd_type <= i_read_type;
            r_s1_rd_slot <= i_read_slot;
            r_s1_rd_site <= i_read_site;
        end
    end

    assign s1_bit_go = r_s1_valid && adv && (r_s1_cmd == CMD_BIT);
    assign flip      = r_s1_valid && (r_s1_cmd == CMD_BIT) && (r_s1_round != '0)
                       && (r_s1_bit ^ r_prev_q);

    always_comb begin
        new_rec.step = STEP_W'(r_s1_round - ROUND_W'(1));
        new_rec.row  = COORD_W'(r_s1_row);
        new_rec.col  = COORD_W'(r_s1_col);
        new_rec.site = SITE_W'(r_s1_site);
        n_rec0 = r_rec0;
        n_rec1 = r_rec1;
        n_cnt  = r_cnt;
        if (flip) begin
            if (r_cnt == 2'd0) begin
                n_rec0 = new_rec;
            end else if (r_cnt == 2'd1) begin
                n_rec1 = new_rec;
            end
            if (r_cnt != 2'd3) begin
                n_cnt = r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_rec0 <= '0;
            r_rec1 <= '0;
        end else if (s1_bit_go) begin
            if (r_s1_last) begin
                r_cnt  <= '0;
                r_rec0 <= '0;
                r_rec1 <= '0;
            end else begin
                r_cnt  <= n_cnt;
                r_rec0 <= n_rec0;
                r_rec1 <= n_rec1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid && ((r_s1_cmd == CMD_READ) || r_s1_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_kind    <= (r_s1_cmd == CMD_READ) ? RESULT_READ : RESULT_OUTCOME;
            r_s2_cnt     <= n_cnt;
            r_s2_rec0    <= n_rec0;
            r_s2_rec1    <= n_rec1;
            r_s2_rd_type <= r_s1_rd_type;
            r_s2_rd_slot <= r_s1_rd_slot;
            r_s2_rd_site <= r_s1_rd_site;
        end
    end

    // single flip: step toward the boundary, off-grid gives nothing
    assign pos_sum  = {1'b0, r_s2_rec0.row} + {1'b0, r_s2_rec0.col};
    assign step_dbl = {r_s2_rec0.step, 1'b0};

    always_comb begin
        one_hit  = 1'b0;
        one_site = r_s2_rec0.site;
        if (r_s2_rec0.col[0]) begin
            if (pos_sum < BSUM) begin
                one_hit  = (r_s2_rec0.col != '0);
                one_site = r_s2_rec0.site - SITE_W'(1);
            end else if (pos_sum > BSUM) begin
                one_hit  = (r_s2_rec0.col != COORD_W'(WIDTH - 1));
                one_site = r_s2_rec0.site + SITE_W'(1);
            end
        end else begin
            if (r_s2_rec0.row < r_s2_rec0.col) begin
                one_hit  = (r_s2_rec0.row != '0);
                one_site = r_s2_rec0.site - SITE_W'(WIDTH);
            end else if (r_s2_rec0.row > r_s2_rec0.col) begin
                one_hit  = (r_s2_rec0.row != COORD_W'(WIDTH - 1));
                one_site = r_s2_rec0.site + SITE_W'(WIDTH);
            end
        end
    end

    // two flips: data, measurement or hook edge
    assign d        = {1'b0, r_s2_rec0.site} - {1'b0, r_s2_rec1.site};
    assign ds       = {1'b0, r_s2_rec0.step} - {1'b0, r_s2_rec1.step};
    assign pair_sum = {1'b0, r_s2_rec0.site} + {1'b0, r_s2_rec1.site};
    assign step_sum = SLOT_W'(r_s2_rec0.step) + SLOT_W'(r_s2_rec1.step);
    assign near     = (d == D_P2) || (d == D_M2) || (d == D_PW) || (d == D_MW);
    assign adj      = (ds == DS_P1) || (ds == DS_M1);

    always_comb begin
        two_hit  = 1'b0;
        two_slot = step_sum;
        two_site = pair_sum[SITE_W:1];
        if ((ds == '0) && near) begin
            two_hit  = 1'b1;
            two_slot = step_dbl;
        end else if (adj && (d == '0)) begin
            two_hit  = 1'b1;
            two_site = r_s2_rec0.site;
        end else if (adj && near && (ds[STEP_W] == d[SITE_W])) begin
            two_hit  = 1'b1;
        end
    end

    always_comb begin
        hit      = 1'b0;
        hit_slot = step_dbl;
        hit_site = one_site;
        if (r_s2_cnt == 2'd1) begin
            hit = one_hit;
        end else if (r_s2_cnt == 2'd2) begin
            hit      = two_hit;
            hit_slot = two_slot;
            hit_site = two_site;
        end
    end

    assign rd_ok = (32'(r_s2_rd_slot) < 32'(SLOTS)) && (32'(r_s2_rd_site) < 32'(SITES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (adv) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_kind <= r_s2_kind;
            if (r_s2_kind == RESULT_READ) begin
                r_s3_access  <= rd_ok;
                r_s3_matched <= 1'b0;
                r_s3_flips   <= '0;
                r_s3_type    <= r_s2_rd_type;
                r_s3_slot    <= SLOT_W'(r_s2_rd_slot);
                r_s3_site    <= SITE_W'(r_s2_rd_site);
            end else begin
                r_s3_access  <= hit;
                r_s3_matched <= hit;
                r_s3_flips   <= r_s2_cnt;
                r_s3_type    <= r_s2_rec0.col[0];
                r_s3_slot    <= hit_slot;
                r_s3_site    <= hit_site;
            end
        end
    end

    assign type_slot = (SLOT_W+1)'(r_s3_type ? SLOTS : 0) + (SLOT_W+1)'(r_s3_slot);
    assign o_push    = r_s3_valid && adv;

    always_comb begin
        o_job.kind      = r_s3_kind;
        o_job.access    = r_s3_access;
        o_job.matched   = r_s3_matched;
        o_job.flips     = r_s3_flips;
        o_job.edge_type = r_s3_matched & r_s3_type;
        o_job.edge_slot = r_s3_matched ? PORT_SLOT_W'(r_s3_slot) : '0;
        o_job.edge_site = r_s3_matched ? PORT_SITE_W'(r_s3_site) : '0;
        o_job.idx       = IDX_W'(IDX_W'(type_slot) * IDX_W'(SITES) + IDX_W'(r_s3_site));
    end

endmodule

[design/sfec_queue.sv]
module sfec_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sfec_pkg::t_job       i_job,
    input  logic                 i_pop,
    output sfec_pkg::t_job       o_job,
    output sfec_pkg::t_q_status  o_status
);
    import sfec_pkg::*;

    t_job              r_slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count, n_count;

    always_comb begin
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_job;
        end
    end

    assign o_job          = r_slots[r_rd_ptr];
    assign o_status.full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

[design/sfec_back.sv]
module sfec_back #(
    parameter int WIDTH      = 9,
    parameter int ROUNDS     = 8,
    parameter int COUNT_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sfec_pkg::t_job                    i_job,
    input  sfec_pkg::t_q_status               i_q,
    output logic                              o_pop,
    output sfec_pkg::t_back_status            o_status,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_result_kind,
    output logic                              o_matched,
    output logic [1:0]                        o_flips_seen,
    output logic                              o_edge_type,
    output logic [sfec_pkg::PORT_SLOT_W-1:0]  o_edge_slot,
    output logic [sfec_pkg::PORT_SITE_W-1:0]  o_edge_site,
    output logic [sfec_pkg::VALUE_W-1:0]      o_counter_value
);
    import sfec_pkg::*;

    localparam int SITES      = WIDTH * WIDTH;
    localparam int SLOTS      = 2 * ROUNDS - 1;
    localparam int HIST_DEPTH = 2 * SLOTS * SITES;
    localparam int HIST_W     = $clog2(HIST_DEPTH);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [COUNT_BITS-1:0] r_hist [HIST_DEPTH];
    logic [COUNT_BITS-1:0] r_rd_data;
    logic [COUNT_BITS-1:0] r_fwd_data;
    logic                  r_fwd;
    logic                  r_clr_active;
    logic [HIST_W-1:0]     r_clr_addr;
    logic                  r_e_valid;
    t_job                  r_e_job;
    logic                  r_out_valid;

    logic                  e_adv;
    logic                  e_wr;
    logic [HIST_W-1:0]     e_addr;
    logic [HIST_W-1:0]     job_addr;
    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] bump;
    logic                  wr_en;
    logic [HIST_W-1:0]     wr_addr;
    logic [COUNT_BITS-1:0] wr_data;

    assign e_adv    = !r_out_valid || i_out_ready;
    assign o_pop    = !i_q.empty && !r_clr_active && (!r_e_valid || e_adv);
    assign e_addr   = r_e_job.idx[HIST_W-1:0];
    assign job_addr = i_job.idx[HIST_W-1:0];
    assign cur      = r_fwd ? r_fwd_data : r_rd_data;
    assign bump     = (cur == COUNT_MAX) ? cur : cur + 1'b1;
    assign e_wr     = r_e_valid && e_adv && (r_e_job.kind == RESULT_OUTCOME) && r_e_job.access;

    always_comb begin
        wr_en   = r_clr_active || e_wr;
        wr_addr = r_clr_active ? r_clr_addr : e_addr;
        wr_data = r_clr_active ? '0 : bump;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_hist[wr_addr] <= wr_data;
        end
        if (o_pop && i_job.access) begin
            r_rd_data <= r_hist[job_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_e_valid    <= 1'b0;
            r_fwd        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_clr_active) begin
                if (r_clr_addr == HIST_W'(HIST_DEPTH - 1)) begin
                    r_clr_active <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (o_pop) begin
                r_e_valid <= 1'b1;
                // write of the leaving op lands on the same edge as this read
                r_fwd     <= e_wr && (e_addr == job_addr);
            end else if (e_adv) begin
                r_e_valid <= 1'b0;
            end
            if (r_e_valid && e_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_e_job    <= i_job;
            r_fwd_data <= bump;
        end
        if (r_e_valid && e_adv) begin
            o_result_kind   <= r_e_job.kind;
            o_matched       <= r_e_job.matched;
            o_flips_seen    <= r_e_job.flips;
            o_edge_type     <= r_e_job.edge_type;
            o_edge_slot     <= r_e_job.edge_slot;
            o_edge_site     <= r_e_job.edge_site;
            o_counter_value <= ((r_e_job.kind == RESULT_READ) && r_e_job.access)
                               ? VALUE_W'(cur) : '0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status.clearing = r_clr_active;

endmodule

[design/syndrome_flip_edge_counter.sv]
// Syndrome flip edge counter. Takes one beat per cycle while the queue has
// room and no sweep runs: a syndrome bit of the shot in progress (rounds 0
// to ROUNDS, sites row-major) or a histogram read. The last bit of a shot
// gives an outcome beat; a read gives its counter value; other bits give
// nothing. The sustained rate is one beat per cycle, set by the one-read,
// one-write previous-round store in the front part and the read-then-write
// histogram memory in the back part; a four-entry queue between them absorbs
// output stalls. After reset the histogram is swept to zero, one counter a
// cycle, over all 2*(2*ROUNDS-1)*WIDTH*WIDTH counters (2430 at the default
// sizes), and no beat is taken during that sweep.
module syndrome_flip_edge_counter #(
    parameter int WIDTH        = 9,
    parameter int ROUNDS       = 8,
    parameter int BOUNDARY_SUM = 8,
    parameter int COUNT_BITS   = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_command,
    input  logic                              i_syndrome_bit,
    input  logic                              i_read_type,
    input  logic [sfec_pkg::PORT_SLOT_W-1:0]  i_read_slot,
    input  logic [sfec_pkg::PORT_SITE_W-1:0]  i_read_site,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_result_kind,
    output logic                              o_matched,
    output logic [1:0]                        o_flips_seen,
    output logic                              o_edge_type,
    output logic [sfec_pkg::PORT_SLOT_W-1:0]  o_edge_slot,
    output logic [sfec_pkg::PORT_SITE_W-1:0]  o_edge_site,
    output logic [sfec_pkg::VALUE_W-1:0]      o_counter_value
);
    import sfec_pkg::*;

    t_back_status back_status;
    t_q_status    q_status;
    logic         q_push;
    logic         q_pop;
    t_job         push_job;
    t_job         head_job;

    sfec_front #(
        .WIDTH        (WIDTH),
        .ROUNDS       (ROUNDS),
        .BOUNDARY_SUM (BOUNDARY_SUM)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_syndrome_bit (i_syndrome_bit),
        .i_read_type    (i_read_type),
        .i_read_slot    (i_read_slot),
        .i_read_site    (i_read_site),
        .i_back         (back_status),
        .i_q            (q_status),
        .o_push         (q_push),
        .o_job          (push_job)
    );

    sfec_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_job    (push_job),
        .i_pop    (q_pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    sfec_back #(
        .WIDTH      (WIDTH),
        .ROUNDS     (ROUNDS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job           (head_job),
        .i_q             (q_status),
        .o_pop           (q_pop),
        .o_status        (back_status),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_kind   (o_result_kind),
        .o_matched       (o_matched),
        .o_flips_seen    (o_flips_seen),
        .o_edge_type     (o_edge_type),
        .o_edge_slot     (o_edge_slot),
        .o_edge_site     (o_edge_site),
        .o_counter_value (o_counter_value)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_status.full)
        else $error("push into full queue");

    a_no_beat_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.clearing |-> !o_in_ready)
        else $error("beat taken during histogram sweep");

    a_read_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_result_kind == RESULT_READ)) |-> (!o_matched && (o_flips_seen == 2'd0)))
        else $error("read result carries outcome fields");

    a_miss_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_result_kind == RESULT_OUTCOME) && !o_matched)
            |-> ((o_edge_slot == '0) && (o_edge_site == '0) && (o_counter_value == '0)))
        else $error("unmatched outcome carries edge fields");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import sfec_pkg::*;

    localparam int GRID_W      = 9;
    localparam int N_ROUNDS    = 8;
    localparam int DIAG_SUM    = 8;
    localparam int NSITES      = GRID_W * GRID_W;
    localparam int NSLOTS      = 2 * N_ROUNDS - 1;
    localparam int HDEPTH      = 2 * NSLOTS * NSITES;
    localparam int unsigned COUNT_MAX = 32'hFFFF_FFFF;
    localparam int STALL_LIMIT = 20000;
    localparam int N_SHOTS     = 2;
    localparam int MIN_BEATS   = 1650;
    localparam int PHASE_BEATS = 100;
    localparam int DRAIN_WAIT  = 16;

    typedef enum int {
        SHOT_QUIET,
        SHOT_SINGLE,
        SHOT_SPACE_PAIR,
        SHOT_TIME_PAIR,
        SHOT_HOOK_PAIR,
        SHOT_ANY_PAIR,
        SHOT_BURST,
        SHOT_NOISE
    } t_shot_kind;

    typedef enum int {
        READ_LAST_HIT,
        READ_IN_RANGE,
        READ_ANY
    } t_read_mode;

    typedef struct packed {
        logic                   kind;
        logic                   matched;
        logic [1:0]             flips;
        logic                   edge_type;
        logic [PORT_SLOT_W-1:0] slot;
        logic [PORT_SITE_W-1:0] site;
        logic [VALUE_W-1:0]     value;
    } t_hist_result;

    // Tracks the shot in progress and the edge histogram, queues expected beats
    class edge_scoreboard;
        bit           prev_bits[NSITES];
        int           rec_step[2];
        int           rec_row[2];
        int           rec_col[2];
        int           flip_cnt;
        int           round_pos;
        int           site_pos;
        int unsigned  counts[HDEPTH];
        t_hist_result expected_q[$];
        int           errors;
        bit           have_hit;
        bit           hit_type;
        int           hit_slot;
        int           hit_site;

        function int pending();
            return expected_q.size();
        endfunction

        function bit near_flat(int d);
            return d == 2 || d == -2 || d == 2 * GRID_W || d == -2 * GRID_W;
        endfunction

        function bit match_edge(output int etype, output int eslot, output int esite);
            int r, c, id1, id2, d, ds;
            bit adj;
            etype = rec_col[0] & 1;
            eslot = 0;
            esite = 0;
            if (flip_cnt == 1) begin
                r = rec_row[0];
                c = rec_col[0];
                eslot = 2 * rec_step[0];
                if (etype == 1) begin
                    if (r + c < DIAG_SUM) c--;
                    else if (r + c > DIAG_SUM) c++;
                    else return 1'b0;
                end else begin
                    if (r < c) r--;
                    else if (r > c) r++;
                    else return 1'b0;
                end
                if (r < 0 || r >= GRID_W || c < 0 || c >= GRID_W) return 1'b0;
                esite = r * GRID_W + c;
                return 1'b1;
            end
            if (flip_cnt == 2) begin
                id1 = rec_row[0] * GRID_W + rec_col[0];
                id2 = rec_row[1] * GRID_W + rec_col[1];
                d = id1 - id2;
                ds = rec_step[0] - rec_step[1];
                adj = (ds == 1 || ds == -1);
                if (ds == 0 && near_flat(d)) begin
                    eslot = 2 * rec_step[0];
                    esite = (id1 + id2) / 2;
                    return 1'b1;
                end
                if (adj && d == 0) begin
                    eslot = rec_step[0] + rec_step[1];
                    esite = id1;
                    return 1'b1;
                end
                if (adj && near_flat(d) && ds * d > 0) begin
                    eslot = rec_step[0] + rec_step[1];
                    esite = (id1 + id2) / 2;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_beat(t_cmd cmd, logic sbit, logic rtype,
                                logic [PORT_SLOT_W-1:0] rslot, logic [PORT_SITE_W-1:0] rsite);
            t_hist_result res;
            int et, es, ei, idx;
            bit hit;
            res = '0;
            if (cmd == CMD_READ) begin
                res.kind = RESULT_READ;
                if (int'(rslot) < NSLOTS && int'(rsite) < NSITES)
                    res.value = counts[(int'(rtype) * NSLOTS + int'(rslot)) * NSITES + int'(rsite)];
                expected_q.push_back(res);
                return;
            end
            if (round_pos > 0 && (sbit ^ prev_bits[site_pos])) begin
                if (flip_cnt < 2) begin
                    rec_step[flip_cnt] = round_pos - 1;
                    rec_row[flip_cnt] = site_pos / GRID_W;
                    rec_col[flip_cnt] = site_pos % GRID_W;
                end
                if (flip_cnt < 3) flip_cnt++;
            end
            prev_bits[site_pos] = sbit;
            site_pos++;
            if (site_pos < NSITES) return;
            site_pos = 0;
            if (round_pos < N_ROUNDS) begin
                round_pos++;
                return;
            end
            // last bit of the shot: match and bump the histogram
            hit = match_edge(et, es, ei);
            res.kind = RESULT_OUTCOME;
            res.flips = 2'(flip_cnt);
            if (hit) begin
                idx = (et * NSLOTS + es) * NSITES + ei;
                if (counts[idx] != COUNT_MAX) counts[idx]++;
                res.matched = 1'b1;
                res.edge_type = et[0];
                res.slot = PORT_SLOT_W'(es);
                res.site = PORT_SITE_W'(ei);
                have_hit = 1'b1;
                hit_type = et[0];
                hit_slot = es;
                hit_site = ei;
            end
            expected_q.push_back(res);
            round_pos = 0;
            flip_cnt = 0;
            rec_step = '{0, 0};
            rec_row = '{0, 0};
            rec_col = '{0, 0};
        endfunction

        function void cmp(string name, logic [31:0] want, logic [31:0] seen);
            if (seen !== want) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, seen);
                errors++;
            end
        endfunction

        function void check_result(t_hist_result got);
            t_hist_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, actual kind %0d value %0d",
                         $time, got.kind, got.value);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            cmp("result_kind", 32'(want.kind), 32'(got.kind));
            cmp("matched", 32'(want.matched), 32'(got.matched));
            cmp("flips_seen", 32'(want.flips), 32'(got.flips));
            cmp("edge_type", 32'(want.edge_type), 32'(got.edge_type));
            cmp("edge_slot", 32'(want.slot), 32'(got.slot));
            cmp("edge_site", 32'(want.site), 32'(got.site));
            cmp("counter_value", want.value, got.value);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic                   i_command = CMD_BIT;
    logic                   i_syndrome_bit = 1'b0;
    logic                   i_read_type = 1'b0;
    logic [PORT_SLOT_W-1:0] i_read_slot = '0;
    logic [PORT_SITE_W-1:0] i_read_site = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic                   o_result_kind;
    logic                   o_matched;
    logic [1:0]             o_flips_seen;
    logic                   o_edge_type;
    logic [PORT_SLOT_W-1:0] o_edge_slot;
    logic [PORT_SITE_W-1:0] o_edge_site;
    logic [VALUE_W-1:0]     o_counter_value;

    edge_scoreboard sb;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  n_beats = 0;
    int  n_shots = 0;
    int  quiet_cycles = 0;
    bit  flips_at[N_ROUNDS][NSITES];
    bit  cur_bits[NSITES];

    syndrome_flip_edge_counter uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_syndrome_bit (i_syndrome_bit),
        .i_read_type    (i_read_type),
        .i_read_slot    (i_read_slot),
        .i_read_site    (i_read_site),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_kind  (o_result_kind),
        .o_matched      (o_matched),
        .o_flips_seen   (o_flips_seen),
        .o_edge_type    (o_edge_type),
        .o_edge_slot    (o_edge_slot),
        .o_edge_site    (o_edge_site),
        .o_counter_value(o_counter_value)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // result checking and no-progress watchdog
    always @(posedge i_clk) begin
        t_hist_result got;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            got = '{o_result_kind, o_matched, o_flips_seen, o_edge_type,
                    o_edge_slot, o_edge_site, o_counter_value};
            sb.check_result(got);
        end
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_beat(t_cmd cmd, logic sbit, logic rtype,
                             logic [PORT_SLOT_W-1:0] rslot, logic [PORT_SITE_W-1:0] rsite);
        // idle phases rotate every PHASE_BEATS beats
        case ((n_beats / PHASE_BEATS) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
        endcase
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_syndrome_bit <= sbit;
        i_read_type    <= rtype;
        i_read_slot    <= rslot;
        i_read_site    <= rsite;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        sb.note_beat(cmd, sbit, rtype, rslot, rsite);
        n_beats++;
    endtask

    task automatic send_bit(logic sbit);
        send_beat(CMD_BIT, sbit, 1'($urandom_range(0, 1)), PORT_SLOT_W'($urandom_range(0, 15)),
                  PORT_SITE_W'($urandom_range(0, 127)));
    endtask

    task automatic send_read(t_read_mode mode);
        logic                   rtype;
        logic [PORT_SLOT_W-1:0] rslot;
        logic [PORT_SITE_W-1:0] rsite;
        rtype = 1'($urandom_range(0, 1));
        rslot = PORT_SLOT_W'($urandom_range(0, 15));
        rsite = PORT_SITE_W'($urandom_range(0, 127));
        if (mode == READ_LAST_HIT && sb.have_hit) begin
            rtype = sb.hit_type;
            rslot = PORT_SLOT_W'(sb.hit_slot);
            rsite = PORT_SITE_W'(sb.hit_site);
        end else if (mode == READ_IN_RANGE) begin
            rslot = PORT_SLOT_W'($urandom_range(0, NSLOTS - 1));
            rsite = PORT_SITE_W'($urandom_range(0, NSITES - 1));
        end
        send_beat(CMD_READ, 1'($urandom_range(0, 1)), rtype, rslot, rsite);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // single flips aimed at the diagonals and at boundaries that leave the grid
    function automatic int pick_single_site(int special);
        int r, c;
        case (special)
            1: begin
                c = 2 * $urandom_range(0, (GRID_W - 1) / 2);
                r = c;
            end
            2: begin
                c = 2 * $urandom_range(0, (GRID_W - 2) / 2) + 1;
                r = DIAG_SUM - c;
            end
            3: begin
                r = 0;
                c = 2 * $urandom_range(1, (GRID_W - 1) / 2);
            end
            4: begin
                r = GRID_W - 1;
                c = 2 * $urandom_range(0, (GRID_W - 2) / 2);
            end
            default: return $urandom_range(0, NSITES - 1);
        endcase
        return r * GRID_W + c;
    endfunction

    function automatic int pick_neighbour(int s);
        int s2;
        do begin
            case ($urandom_range(0, 3))
                0: s2 = s + 2;
                1: s2 = s - 2;
                2: s2 = s + 2 * GRID_W;
                default: s2 = s - 2 * GRID_W;
            endcase
        end while (s2 < 0 || s2 >= NSITES);
        return s2;
    endfunction

    task automatic run_shot(t_shot_kind kind, int special);
        int t, s, r, k;
        foreach (flips_at[i, j]) flips_at[i][j] = 1'b0;
        t = $urandom_range(0, N_ROUNDS - 2);
        s = $urandom_range(0, NSITES - 1);
        case (kind)
            SHOT_SINGLE:
                flips_at[$urandom_range(0, N_ROUNDS - 1)][pick_single_site(special)] = 1'b1;
            SHOT_SPACE_PAIR: begin
                t = $urandom_range(0, N_ROUNDS - 1);
                flips_at[t][s] = 1'b1;
                flips_at[t][pick_neighbour(s)] = 1'b1;
            end
            SHOT_TIME_PAIR: begin
                flips_at[t][s] = 1'b1;
                flips_at[t + 1][s] = 1'b1;
            end
            SHOT_HOOK_PAIR: begin
                flips_at[t][s] = 1'b1;
                flips_at[t + 1][pick_neighbour(s)] = 1'b1;
            end
            SHOT_ANY_PAIR:
                repeat (2) flips_at[$urandom_range(0, N_ROUNDS - 1)][$urandom_range(0, NSITES - 1)] = 1'b1;
            SHOT_BURST:
                repeat ($urandom_range(3, 8))
                    flips_at[$urandom_range(0, N_ROUNDS - 1)][$urandom_range(0, NSITES - 1)] = 1'b1;
            default: ;
        endcase
        for (r = 0; r <= N_ROUNDS; r++) begin
            for (k = 0; k < NSITES; k++) begin
                if (r == 0 || kind == SHOT_NOISE)
                    cur_bits[k] = 1'($urandom_range(0, 1));
                else
                    cur_bits[k] = cur_bits[k] ^ flips_at[r - 1][k];
                if ($urandom_range(0, 99) < 3) send_read(t_read_mode'($urandom_range(0, 2)));
                send_bit(cur_bits[k]);
            end
        end
        n_shots++;
        // read straight after the outcome to catch update hazards
        if ($urandom_range(0, 1)) send_read(READ_LAST_HIT);
        drain_results();
    endtask

    initial begin
        t_shot_kind kind;
        sb = new;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reads at the address extremes, in and out of range
        send_beat(CMD_READ, 1'b0, 1'b0, 4'd0, 7'd0);
        send_beat(CMD_READ, 1'b1, 1'b1, 4'd14, 7'd80);
        send_beat(CMD_READ, 1'b0, 1'b0, 4'd15, 7'd0);
        send_beat(CMD_READ, 1'b1, 1'b1, 4'd0, 7'd81);
        send_beat(CMD_READ, 1'b0, 1'b0, 4'd15, 7'd127);
        send_beat(CMD_READ, 1'b1, 1'b1, 4'd7, 7'd40);

        repeat (N_SHOTS) begin
            case ($urandom_range(0, 9))
                0: kind = SHOT_QUIET;
                1, 2, 9: kind = SHOT_SINGLE;
                3: kind = SHOT_SPACE_PAIR;
                4: kind = SHOT_TIME_PAIR;
                5: kind = SHOT_HOOK_PAIR;
                6: kind = SHOT_ANY_PAIR;
                7: kind = SHOT_BURST;
                default: kind = SHOT_NOISE;
            endcase
            run_shot(kind, $urandom_range(0, 4));
        end

        while (n_beats < MIN_BEATS) send_read(t_read_mode'($urandom_range(0, 2)));

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
